/* hdl/kfd_pkg.sv */
// Shared types and constants for the KISS frame decoder.
// No dependencies; every other file of the block refers to this package.
package kfd_pkg;

    localparam int BYTE_W          = 8;
    localparam int KIND_W          = 2;
    localparam int FRAME_LEN_W     = 16;
    localparam int LENGTH_BITS_DEF = 16;

    localparam logic [BYTE_W-1:0] KISS_FEND  = 8'hC0;
    localparam logic [BYTE_W-1:0] KISS_FESC  = 8'hDB;
    localparam logic [BYTE_W-1:0] KISS_TFEND = 8'hDC;
    localparam logic [BYTE_W-1:0] KISS_TFESC = 8'hDD;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_DROP = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [BYTE_W-1:0]      data;
        logic [FRAME_LEN_W-1:0] length;
    } t_result;

    // Decode outcome for the item in the input register.
    typedef struct packed {
        logic    has_result;
        t_result result;
    } t_dec;

endpackage

/* hdl/kfd_if.sv */
// Valid/ready channel interfaces for the KISS frame decoder.
// Depends on kfd_pkg for field widths.
interface kfd_in_if;
    logic                       valid;
    logic                       ready;
    logic [kfd_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface kfd_out_if;
    logic                            valid;
    logic                            ready;
    logic [kfd_pkg::KIND_W-1:0]      result_kind;
    logic [kfd_pkg::BYTE_W-1:0]      data_byte;
    logic [kfd_pkg::FRAME_LEN_W-1:0] frame_length;

    modport source (output valid, output result_kind, output data_byte,
                    output frame_length, input ready);
    modport sink   (input valid, input result_kind, input data_byte,
                    input frame_length, output ready);
endinterface

/* hdl/kfd_in_stage.sv */
// Input register of the KISS frame decoder: holds one raw byte for decode.
// Depends on kfd_pkg.
module kfd_in_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [kfd_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_adv,
    output logic                       o_ready,
    output logic                       o_valid,
    output logic [kfd_pkg::BYTE_W-1:0] o_byte
);

    logic                       r_valid;
    logic [kfd_pkg::BYTE_W-1:0] r_byte;

    assign o_ready = !r_valid || i_adv;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

/* hdl/kfd_decode.sv */
// Framing state and unescape logic of the KISS frame decoder.
// Depends on kfd_pkg; state advances only when the held item moves on.
module kfd_decode #(
    parameter int LENGTH_BITS = kfd_pkg::LENGTH_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic [kfd_pkg::BYTE_W-1:0] i_byte,
    output kfd_pkg::t_dec              o_dec
);

    logic                   r_start_seen, n_start_seen;
    logic                   r_in_payload, n_in_payload;
    logic                   r_esc,        n_esc;
    logic [LENGTH_BITS-1:0] r_count,      n_count;
    logic [LENGTH_BITS-1:0] count_inc;

    // Saturate at all ones.
    assign count_inc = (&r_count) ? r_count : r_count + LENGTH_BITS'(1);

    always_comb begin
        n_start_seen        = r_start_seen;
        n_in_payload        = r_in_payload;
        n_esc               = r_esc;
        n_count             = r_count;
        o_dec.has_result    = 1'b0;
        o_dec.result.kind   = kfd_pkg::KIND_DATA;
        o_dec.result.data   = '0;
        o_dec.result.length = '0;

        if (i_byte == kfd_pkg::KISS_FEND) begin
            if (r_in_payload) begin
                n_start_seen        = 1'b0;
                n_in_payload        = 1'b0;
                n_esc               = 1'b0;
                o_dec.has_result    = 1'b1;
                o_dec.result.kind   = kfd_pkg::KIND_END;
                o_dec.result.length = kfd_pkg::FRAME_LEN_W'(r_count);
            end else begin
                n_count      = '0;
                n_start_seen = 1'b1;
            end
        end else if (i_byte == kfd_pkg::KISS_FESC) begin
            if (r_in_payload) begin
                n_esc = 1'b1;
            end
        end else if (r_in_payload || r_start_seen) begin
            // First plain byte after an armed start opens the payload.
            n_start_seen = 1'b0;
            n_in_payload = 1'b1;
            if (!r_esc) begin
                n_count           = count_inc;
                o_dec.has_result  = 1'b1;
                o_dec.result.data = i_byte;
            end else begin
                n_esc = 1'b0;
                if (i_byte == kfd_pkg::KISS_TFESC) begin
                    n_count           = count_inc;
                    o_dec.has_result  = 1'b1;
                    o_dec.result.data = kfd_pkg::KISS_FESC;
                end else if (i_byte == kfd_pkg::KISS_TFEND) begin
                    n_count           = count_inc;
                    o_dec.has_result  = 1'b1;
                    o_dec.result.data = kfd_pkg::KISS_FEND;
                end else begin
                    // Bad escape: drop the frame, keep the count.
                    n_start_seen      = 1'b0;
                    n_in_payload      = 1'b0;
                    o_dec.has_result  = 1'b1;
                    o_dec.result.kind = kfd_pkg::KIND_DROP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_seen <= 1'b0;
            r_in_payload <= 1'b0;
            r_esc        <= 1'b0;
            r_count      <= '0;
        end else if (i_adv) begin
            r_start_seen <= n_start_seen;
            r_in_payload <= n_in_payload;
            r_esc        <= n_esc;
            r_count      <= n_count;
        end
    end

endmodule

/* hdl/kfd_out_stage.sv */
// Result register of the KISS frame decoder: holds one result until taken.
// Depends on kfd_pkg.
module kfd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  kfd_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output kfd_pkg::t_result o_result
);

    logic             r_valid;
    kfd_pkg::t_result r_result;

    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* hdl/kiss_frame_decoder.sv */
// KISS frame decoder: takes one raw serial byte per item and emits at most one
// result per byte (a decoded payload byte, a frame end with its length, or a
// drop on a bad escape). The block accepts one byte every clock cycle unless
// stalled by a waiting result; each byte is held in the input register and its
// result goes to the result register as the byte moves on. Ready falls only
// when the result register is full, not taken, and the held byte has a result.
// Frame length counts LENGTH_BITS bits and saturates at all ones.
module kiss_frame_decoder #(
    parameter int LENGTH_BITS = kfd_pkg::LENGTH_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kfd_in_if.sink    i_in,
    kfd_out_if.source o_out
);

    logic                       in_valid;
    logic [kfd_pkg::BYTE_W-1:0] in_byte;
    logic                       adv;
    logic                       out_valid;
    kfd_pkg::t_dec              dec;
    kfd_pkg::t_result           out_result;

    // Move the held byte on unless its result would overwrite a waiting one.
    assign adv = in_valid && (!dec.has_result || !out_valid || o_out.ready);

    kfd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_byte  (i_in.in_byte),
        .i_adv   (adv),
        .o_ready (i_in.ready),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    kfd_decode #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (in_byte),
        .o_dec   (dec)
    );

    kfd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (adv && dec.has_result),
        .i_result (dec.result),
        .i_ready  (o_out.ready),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_out.valid        = out_valid;
    assign o_out.result_kind  = out_result.kind;
    assign o_out.data_byte    = out_result.data;
    assign o_out.frame_length = out_result.length;

endmodule

/* hdl/kfd_checker.sv */
// Port-level assertions for the KISS frame decoder, bound to the top level.
// Depends on kfd_pkg and kiss_frame_decoder.
module kfd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [kfd_pkg::KIND_W-1:0]      i_kind,
    input logic [kfd_pkg::BYTE_W-1:0]      i_data,
    input logic [kfd_pkg::FRAME_LEN_W-1:0] i_length
);

    // No result survives reset.
    a_reset_clears: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind == kfd_pkg::KIND_DATA || i_kind == kfd_pkg::KIND_END ||
                         i_kind == kfd_pkg::KIND_DROP))
        else $error("illegal result kind");

    // Payload opens on a counted byte, so a frame end never reports zero.
    a_end_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind == kfd_pkg::KIND_END) |-> (i_length != '0 && i_data == '0))
        else $error("frame end with zero length or stray data");

    a_data_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_kind != kfd_pkg::KIND_END) |-> i_length == '0)
        else $error("length set on a non-end result");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_kind) &&
                                          $stable(i_data) && $stable(i_length)))
        else $error("stalled result changed");

endmodule

bind kiss_frame_decoder kfd_checker u_kfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.result_kind),
    .i_data      (o_out.data_byte),
    .i_length    (o_out.frame_length)
);
